/* hw/rtl/cpa_pkg.sv */
// ----------------------------------------------------------------------------
// cpa_pkg
// Shared types, codes and defaults for the contiguous page allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package cpa_pkg;

    localparam int DEF_NUM_PAGES  = 16;
    localparam int DEF_PAGE_BYTES = 64;

    localparam int REQ_W    = 2;
    localparam int BYTES_W  = 11;
    localparam int PAGE_W   = 5;
    localparam int STATUS_W = 2;

    // request codes
    localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd0;
    localparam logic [REQ_W-1:0] REQ_FREE  = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    // result status codes
    localparam logic [STATUS_W-1:0] STS_OK            = 2'd0;
    localparam logic [STATUS_W-1:0] STS_INVALID       = 2'd1;
    localparam logic [STATUS_W-1:0] STS_ALREADY_FREE  = 2'd2;
    localparam logic [STATUS_W-1:0] STS_OUT_OF_BOUNDS = 2'd3;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN
    } state_t;

    // controller to datapath
    typedef struct packed {
        logic load;         // latch the request, reset the scan
        logic step;         // move the scan one page on
        logic finish_exec;  // post the result of a free, clear or invalid item
        logic finish_scan;  // post the result of an allocate scan
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_scan;   // item at the input is an allocate of nonzero size
        logic hit;          // current page completes a free run
        logic last;         // current page is the top page
        logic out_free;     // output register can take a result this cycle
    } sts_t;

endpackage

`default_nettype wire

/* hw/rtl/cpa_ctrl.sv */
// ----------------------------------------------------------------------------
// cpa_ctrl
// Controller state machine: accepts an item, sequences the page scan and
// posts the result when the output register has room.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire cpa_pkg::sts_t sts,
    output cpa_pkg::cmd_t      cmd
);
    import cpa_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = sts.start_scan ? S_SCAN : S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            S_SCAN:
            begin
                if ((sts.hit || sts.last) && sts.out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready = 1'b0;
        cmd      = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                cmd.load = in_valid;
            end
            S_EXEC:
            begin
                cmd.finish_exec = sts.out_free;
            end
            S_SCAN:
            begin
                // a finished scan holds its page until the output has room
                if (sts.hit || sts.last)
                begin
                    cmd.finish_scan = sts.out_free;
                end
                else
                begin
                    cmd.step = 1'b1;
                end
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

/* hw/rtl/cpa_datapath.sv */
// ----------------------------------------------------------------------------
// cpa_datapath
// Taken map, request registers, first-fit run scanner and output register.
// ----------------------------------------------------------------------------
`default_nettype none

module cpa_datapath #(
    parameter int NUM_PAGES  = cpa_pkg::DEF_NUM_PAGES,
    parameter int PAGE_BYTES = cpa_pkg::DEF_PAGE_BYTES
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic [cpa_pkg::REQ_W-1:0]      req_type,
    input  wire logic [cpa_pkg::BYTES_W-1:0]    alloc_bytes,
    input  wire logic [cpa_pkg::PAGE_W-1:0]     page_id,
    input  wire cpa_pkg::cmd_t                  cmd,
    output cpa_pkg::sts_t                       sts,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [cpa_pkg::STATUS_W-1:0]        status,
    output logic [cpa_pkg::PAGE_W-1:0]          first_page,
    output logic [cpa_pkg::PAGE_W-1:0]          page_count
);
    import cpa_pkg::*;

    localparam int IDX_W = $clog2(NUM_PAGES);
    localparam int CNT_W = $clog2(NUM_PAGES + 1);
    // a run stops growing once it covers the request, so this width holds it
    localparam int RB_W  = $clog2((1 << BYTES_W) + PAGE_BYTES);

    logic [NUM_PAGES-1:0] taken_reg;
    logic [NUM_PAGES-1:0] taken_next;

    logic [REQ_W-1:0]   req_reg;
    logic [BYTES_W-1:0] bytes_reg;
    logic [PAGE_W-1:0]  page_id_reg;

    logic [IDX_W-1:0] idx_reg;
    logic [CNT_W-1:0] run_reg;
    logic [RB_W-1:0]  run_bytes_reg;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] status_reg;
    logic [PAGE_W-1:0]   first_page_reg;
    logic [PAGE_W-1:0]   page_count_reg;

    logic                cur_free;
    logic [CNT_W-1:0]    run_n;
    logic [RB_W-1:0]     run_bytes_n;
    logic [IDX_W-1:0]    start_idx;
    logic                free_id_ok;
    logic [IDX_W-1:0]    free_idx;
    logic [STATUS_W-1:0] res_status;
    logic [PAGE_W-1:0]   res_first;
    logic [PAGE_W-1:0]   res_count;

    // scanner: extend or restart the free run at the current page
    always_comb
    begin
        cur_free    = !taken_reg[idx_reg];
        run_n       = cur_free ? run_reg + CNT_W'(1) : '0;
        run_bytes_n = cur_free ? run_bytes_reg + RB_W'(PAGE_BYTES) : '0;
        start_idx   = idx_reg - IDX_W'(run_reg);
    end

    assign sts.start_scan = (req_type == REQ_ALLOC) && (alloc_bytes != '0);
    assign sts.hit        = cur_free && (run_bytes_n >= RB_W'(bytes_reg));
    assign sts.last       = (32'(idx_reg) == 32'(NUM_PAGES - 1));
    assign sts.out_free   = !out_valid_reg || out_ready;

    assign free_id_ok = (page_id_reg != '0) && (32'(page_id_reg) <= 32'(NUM_PAGES));
    assign free_idx   = IDX_W'(page_id_reg - PAGE_W'(1));

    always_comb
    begin
        taken_next = taken_reg;
        res_status = STS_INVALID;
        res_first  = '0;
        res_count  = '0;
        if (cmd.finish_scan)
        begin
            if (sts.hit)
            begin
                res_status = STS_OK;
                res_first  = PAGE_W'(32'(start_idx) + 1);
                res_count  = PAGE_W'(run_n);
                for (int j = 0; j < NUM_PAGES; j++)
                begin
                    if ((32'(j) >= 32'(start_idx)) && (32'(j) <= 32'(idx_reg)))
                    begin
                        taken_next[j] = 1'b1;
                    end
                end
            end
            else
            begin
                res_status = STS_OUT_OF_BOUNDS;
            end
        end
        else if (cmd.finish_exec)
        begin
            priority if (req_reg == REQ_FREE)
            begin
                if (!free_id_ok)
                begin
                    res_status = STS_INVALID;
                end
                else if (!taken_reg[free_idx])
                begin
                    res_status = STS_ALREADY_FREE;
                end
                else
                begin
                    res_status           = STS_OK;
                    taken_next[free_idx] = 1'b0;
                end
            end
            else if (req_reg == REQ_CLEAR)
            begin
                res_status = STS_OK;
                taken_next = '0;
            end
            else
            begin
                // zero-size allocate and the unused code
                res_status = STS_INVALID;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            taken_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            taken_reg <= taken_next;
            if (cmd.finish_exec || cmd.finish_scan)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            req_reg       <= req_type;
            bytes_reg     <= alloc_bytes;
            page_id_reg   <= page_id;
            idx_reg       <= '0;
            run_reg       <= '0;
            run_bytes_reg <= '0;
        end
        else if (cmd.step)
        begin
            idx_reg       <= idx_reg + IDX_W'(1);
            run_reg       <= run_n;
            run_bytes_reg <= run_bytes_n;
        end
        if (cmd.finish_exec || cmd.finish_scan)
        begin
            status_reg     <= res_status;
            first_page_reg <= res_first;
            page_count_reg <= res_count;
        end
    end

    assign out_valid  = out_valid_reg;
    assign status     = status_reg;
    assign first_page = first_page_reg;
    assign page_count = page_count_reg;

endmodule

`default_nettype wire

/* hw/rtl/contiguous_page_allocator.sv */
// ----------------------------------------------------------------------------
// contiguous_page_allocator
// First-fit allocator of runs of consecutive pages over a one-bit taken map.
// ----------------------------------------------------------------------------
// An allocate item walks the taken map one page per cycle from the lowest
// page, keeping the length of the current free run in bytes, and stops at the
// first page where the run covers the requested size, or at the top page when
// no run fits. Free, clear, zero-size and unknown items need no walk and post
// their result straight from the exec state. One item is in work at a time; a
// finished result waits in the output register while the next item is
// accepted, and a finished item holds there until that register has room. The
// map resets to all pages free.
`default_nettype none

module contiguous_page_allocator #(
    parameter int NUM_PAGES  = cpa_pkg::DEF_NUM_PAGES,
    parameter int PAGE_BYTES = cpa_pkg::DEF_PAGE_BYTES
) (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        in_valid,
    output logic                             in_ready,
    input  wire logic [cpa_pkg::REQ_W-1:0]   req_type,
    input  wire logic [cpa_pkg::BYTES_W-1:0] alloc_bytes,
    input  wire logic [cpa_pkg::PAGE_W-1:0]  page_id,
    output logic                             out_valid,
    input  wire logic                        out_ready,
    output logic [cpa_pkg::STATUS_W-1:0]     status,
    output logic [cpa_pkg::PAGE_W-1:0]       first_page,
    output logic [cpa_pkg::PAGE_W-1:0]       page_count
);
    import cpa_pkg::*;

    cmd_t cmd;
    sts_t sts;

    cpa_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    cpa_datapath #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) u_datapath (
        .clk         (clk),
        .rst_n       (rst_n),
        .req_type    (req_type),
        .alloc_bytes (alloc_bytes),
        .page_id     (page_id),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .first_page  (first_page),
        .page_count  (page_count)
    );

    // the input is not ready in the cycle after an item is accepted
    a_busy_after_accept: assert property (
        @(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready) |=> !in_ready
    ) else $error("input taken again straight after an item");

    // a fresh result only comes out of a cycle spent working on an item
    a_result_from_work: assert property (
        @(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(!in_ready)
    ) else $error("result posted without an item in work");

    // only a successful allocate reports a run
    a_run_only_on_ok: assert property (
        @(posedge clk) disable iff (!rst_n)
        (out_valid && (status != STS_OK)) |-> ((first_page == '0) && (page_count == '0))
    ) else $error("run reported with an error status");

endmodule

`default_nettype wire

/* test/tb_contiguous_page_allocator.sv */
// ----------------------------------------------------------------------------
// tb_contiguous_page_allocator
// Self-checking testbench for the first-fit contiguous page allocator.
// ----------------------------------------------------------------------------
// A short table of directed items covers the size and page extremes, every
// request code and every error status. A long random run of allocate, free
// and clear items follows. Both sides of the handshake idle at random. Every
// result is compared with the next entry of a queue of expected outcomes,
// filled as items are accepted, from typed table rows or else from an in-bench model of the taken map.
`default_nettype none

module tb_contiguous_page_allocator;

    import cpa_pkg::*;

    localparam int NUM_PAGES   = DEF_NUM_PAGES;
    localparam int PAGE_BYTES  = DEF_PAGE_BYTES;
    localparam int NUM_RANDOM  = 1950;
    localparam int MAX_SHOWN   = 10;
    localparam int DRAIN_IDLE  = 40;

    // request code the block does not define
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [PAGE_W-1:0]   first;
        logic [PAGE_W-1:0]   count;
    } alloc_outcome_t;

    typedef struct packed {
        logic [REQ_W-1:0]   req;
        logic [BYTES_W-1:0] bytes;
        logic [PAGE_W-1:0]  id;
        logic               typed;
        alloc_outcome_t     want;
    } stim_row_t;

    localparam int NUM_DIRECTED = 25;

    localparam stim_row_t DIRECTED_ROWS [NUM_DIRECTED] = '{
        '{REQ_ALLOC,  11'd0,    5'd0,  1'b1, '{STS_INVALID,       5'd0,  5'd0}},
        '{REQ_ALLOC,  11'd1,    5'd0,  1'b1, '{STS_OK,            5'd1,  5'd1}},
        '{REQ_ALLOC,  11'd64,   5'd0,  1'b1, '{STS_OK,            5'd2,  5'd1}},
        '{REQ_ALLOC,  11'd65,   5'd0,  1'b1, '{STS_OK,            5'd3,  5'd2}},
        '{REQ_FREE,   11'd0,    5'd0,  1'b1, '{STS_INVALID,       5'd0,  5'd0}},
        '{REQ_FREE,   11'd0,    5'd17, 1'b1, '{STS_INVALID,       5'd0,  5'd0}},
        '{REQ_FREE,   11'd2047, 5'd31, 1'b1, '{STS_INVALID,       5'd0,  5'd0}},
        '{REQ_FREE,   11'd0,    5'd16, 1'b1, '{STS_ALREADY_FREE,  5'd0,  5'd0}},
        '{REQ_FREE,   11'd0,    5'd2,  1'b1, '{STS_OK,            5'd0,  5'd0}},
        '{REQ_ALLOC,  11'd128,  5'd0,  1'b0, '{STS_OK,            5'd0,  5'd0}},
        '{REQ_ALLOC,  11'd1024, 5'd0,  1'b1, '{STS_OUT_OF_BOUNDS, 5'd0,  5'd0}},
        '{REQ_ALLOC,  11'd1025, 5'd0,  1'b1, '{STS_OUT_OF_BOUNDS, 5'd0,  5'd0}},
        '{REQ_ALLOC,  11'd2047, 5'd31, 1'b1, '{STS_OUT_OF_BOUNDS, 5'd0,  5'd0}},
        '{REQ_UNUSED, 11'd2047, 5'd31, 1'b1, '{STS_INVALID,       5'd0,  5'd0}},
        '{REQ_CLEAR,  11'd0,    5'd0,  1'b1, '{STS_OK,            5'd0,  5'd0}},
        '{REQ_ALLOC,  11'd1024, 5'd0,  1'b1, '{STS_OK,            5'd1,  5'd16}},
        '{REQ_ALLOC,  11'd1,    5'd0,  1'b1, '{STS_OUT_OF_BOUNDS, 5'd0,  5'd0}},
        '{REQ_FREE,   11'd0,    5'd16, 1'b1, '{STS_OK,            5'd0,  5'd0}},
        '{REQ_ALLOC,  11'd64,   5'd0,  1'b1, '{STS_OK,            5'd16, 5'd1}},
        '{REQ_FREE,   11'd0,    5'd1,  1'b1, '{STS_OK,            5'd0,  5'd0}},
        '{REQ_FREE,   11'd0,    5'd1,  1'b1, '{STS_ALREADY_FREE,  5'd0,  5'd0}},
        '{REQ_ALLOC,  11'd63,   5'd0,  1'b0, '{STS_OK,            5'd0,  5'd0}},
        '{REQ_CLEAR,  11'd1365, 5'd21, 1'b1, '{STS_OK,            5'd0,  5'd0}},
        '{REQ_ALLOC,  11'd960,  5'd0,  1'b0, '{STS_OK,            5'd0,  5'd0}},
        '{REQ_ALLOC,  11'd129,  5'd10, 1'b0, '{STS_OK,            5'd0,  5'd0}}
    };

    logic                clk         = 1'b0;
    logic                rst_n       = 1'b0;
    logic                in_valid    = 1'b0;
    logic                in_ready;
    logic [REQ_W-1:0]    req_type    = REQ_ALLOC;
    logic [BYTES_W-1:0]  alloc_bytes = '0;
    logic [PAGE_W-1:0]   page_id     = '0;
    logic                out_valid;
    logic                out_ready   = 1'b0;
    logic [STATUS_W-1:0] status;
    logic [PAGE_W-1:0]   first_page;
    logic [PAGE_W-1:0]   page_count;

    logic [NUM_PAGES-1:0] taken_pages = '0;
    alloc_outcome_t       pending_outcomes[$];
    int                   n_errors = 0;
    int                   n_shown  = 0;
    bit                   no_idle  = 1'b0;

    contiguous_page_allocator #(
        .NUM_PAGES  (NUM_PAGES),
        .PAGE_BYTES (PAGE_BYTES)
    ) i_dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .req_type    (req_type),
        .alloc_bytes (alloc_bytes),
        .page_id     (page_id),
        .out_valid   (out_valid),
        .out_ready   (out_ready),
        .status      (status),
        .first_page  (first_page),
        .page_count  (page_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // first-fit allocation, free and clear over the taken map, updating it as the block would
    function automatic alloc_outcome_t allocate_or_free(logic [REQ_W-1:0] req,
                                                        logic [BYTES_W-1:0] bytes,
                                                        logic [PAGE_W-1:0] id);
        alloc_outcome_t res;
        int             pages_needed;
        int             run;
        int             start;
        bit             found;
        res   = '{STS_OK, '0, '0};
        found = 1'b0;
        run   = 0;
        if (req == REQ_ALLOC)
        begin
            pages_needed = (int'(bytes) + PAGE_BYTES - 1) / PAGE_BYTES;
            if (bytes == 0)
                res.status = STS_INVALID;
            else if (pages_needed > NUM_PAGES)
                res.status = STS_OUT_OF_BOUNDS;
            else
            begin
                for (int i = 0; i < NUM_PAGES; i++)
                begin
                    if (!found)
                    begin
                        run = taken_pages[i] ? 0 : run + 1;
                        if (run == pages_needed)
                        begin
                            found = 1'b1;
                            start = i + 1 - pages_needed;
                            for (int j = start; j <= i; j++)
                                taken_pages[j] = 1'b1;
                            res.first = PAGE_W'(start + 1);
                            res.count = PAGE_W'(pages_needed);
                        end
                    end
                end
                if (!found)
                    res.status = STS_OUT_OF_BOUNDS;
            end
        end
        else if (req == REQ_FREE)
        begin
            if (id == 0 || int'(id) > NUM_PAGES)
                res.status = STS_INVALID;
            else if (!taken_pages[id - 1])
                res.status = STS_ALREADY_FREE;
            else
                taken_pages[id - 1] = 1'b0;
        end
        else if (req == REQ_CLEAR)
            taken_pages = '0;
        else
            res.status = STS_INVALID;
        return res;
    endfunction

    task automatic report_mismatch(string what, alloc_outcome_t want, alloc_outcome_t got);
        n_errors++;
        if (n_shown < MAX_SHOWN)
        begin
            n_shown++;
            $display({"%0t %s: expected status %0d first %0d count %0d,",
                      " got status %0d first %0d count %0d"},
                     $realtime, what, want.status, want.first, want.count,
                     got.status, got.first, got.count);
        end
    endtask

    // drive one item from a falling edge, wait for it to be taken, leave at a falling edge
    task automatic send_request(logic [REQ_W-1:0] req, logic [BYTES_W-1:0] bytes,
                                logic [PAGE_W-1:0] id, logic typed, alloc_outcome_t want);
        int             gap;
        alloc_outcome_t predicted;
        gap = no_idle ? 0 : $urandom_range(0, 10);
        if (gap != 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid    <= 1'b1;
        req_type    <= req;
        alloc_bytes <= bytes;
        page_id     <= id;
        do
            @(posedge clk);
        while (!in_ready);
        predicted = allocate_or_free(req, bytes, id);
        pending_outcomes.push_back(typed ? want : predicted);
        @(negedge clk);
    endtask

    task automatic wait_for_drain();
        in_valid <= 1'b0;
        while (pending_outcomes.size() != 0)
            @(negedge clk);
    endtask

    // random item, mostly well-formed allocates and frees of taken pages
    task automatic pick_random(output logic [REQ_W-1:0] req, output logic [BYTES_W-1:0] bytes,
                               output logic [PAGE_W-1:0] id);
        int roll;
        int pick;
        roll  = $urandom_range(0, 99);
        bytes = BYTES_W'($urandom);
        id    = PAGE_W'($urandom);
        if (roll < 45)
        begin
            req = REQ_ALLOC;
            pick = $urandom_range(0, 9);
            if (pick < 7)
                bytes = BYTES_W'($urandom_range(1, 3 * PAGE_BYTES));
            else if (pick < 9)
                bytes = BYTES_W'($urandom_range(1, NUM_PAGES * PAGE_BYTES));
        end
        else if (roll < 88)
        begin
            req = REQ_FREE;
            if (taken_pages != 0 && $urandom_range(0, 3) != 0)
            begin
                do
                    pick = $urandom_range(0, NUM_PAGES - 1);
                while (!taken_pages[pick]);
                id = PAGE_W'(pick + 1);
            end
            else if ($urandom_range(0, 1) == 0)
                id = PAGE_W'($urandom_range(1, NUM_PAGES));
        end
        else if (roll < 94)
            req = REQ_CLEAR;
        else if (roll < 97)
        begin
            req   = REQ_ALLOC;
            bytes = (roll == 94) ? '0 : bytes;
        end
        else
            req = REQ_UNUSED;
    endtask

    initial
    begin
        logic [REQ_W-1:0]   req;
        logic [BYTES_W-1:0] bytes;
        logic [PAGE_W-1:0]  id;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        for (int k = 0; k < NUM_DIRECTED; k++)
            send_request(DIRECTED_ROWS[k].req, DIRECTED_ROWS[k].bytes, DIRECTED_ROWS[k].id,
                         DIRECTED_ROWS[k].typed, DIRECTED_ROWS[k].want);
        wait_for_drain();

        for (int n = 0; n < NUM_RANDOM; n++)
        begin
            // every fourth stretch of items runs with no idling on either side
            no_idle = ((n / 150) % 4) == 3;
            if (n == NUM_RANDOM / 2)
                wait_for_drain();
            pick_random(req, bytes, id);
            send_request(req, bytes, id, 1'b0, '0);
        end
        in_valid <= 1'b0;

        while (pending_outcomes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_IDLE) @(posedge clk);
        if (n_errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

    // result side: random back-pressure, each item checked against the oldest outcome
    initial
    begin
        int             stall;
        alloc_outcome_t got;
        alloc_outcome_t want;
        @(posedge rst_n);
        @(negedge clk);
        forever
        begin
            stall = no_idle ? 0 : $urandom_range(0, 10);
            if (stall != 0)
            begin
                out_ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!out_valid);
            got = '{status, first_page, page_count};
            if (pending_outcomes.size() == 0)
                report_mismatch("unexpected result", '0, got);
            else
            begin
                want = pending_outcomes.pop_front();
                if (got.status !== want.status || got.first !== want.first
                    || got.count !== want.count)
                    report_mismatch("result mismatch", want, got);
            end
            @(negedge clk);
        end
    end

    initial
    begin
        #4000000;
        $display("CHECKS FAILED");
        $finish;
    end

endmodule

`default_nettype wire
